// ===== src/move_to_front_list_search_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the move-to-front list search block
// Shared concurrent assertion forms, clocked on clock and quiet in reset.
// ---------------------------------------------------------------------------
`ifndef MOVE_TO_FRONT_LIST_SEARCH_ASSERT_SVH
`define MOVE_TO_FRONT_LIST_SEARCH_ASSERT_SVH

// Same-cycle implication
`define MTF_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define MTF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/mtf_pkg.sv =====
// ---------------------------------------------------------------------------
// Move-to-front list search package
// Sizes, payload types, sequencer states and the count saturation helper.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mtf_pkg;

   localparam int LIST_DEPTH = 256;
   localparam int ADDR_W     = $clog2(LIST_DEPTH);
   localparam int LEN_W      = $clog2(LIST_DEPTH + 1);
   localparam int KEY_W      = 32;
   localparam int COST_W     = 9;
   localparam int CNT_W      = 9;

   typedef logic [KEY_W-1:0]  key_type;
   typedef logic [COST_W-1:0] cost_type;
   typedef logic [CNT_W-1:0]  count_type;
   typedef logic [LEN_W-1:0]  len_type;
   typedef logic [ADDR_W-1:0] addr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_FRONT,
      ST_OUT
   } mtf_state_type;

   // Clamp a preload count to the list depth
   function automatic len_type sat_count(count_type count);
      if (32'(count) > 32'(LIST_DEPTH)) begin
         return LEN_W'(LIST_DEPTH);
      end else begin
         return LEN_W'(count);
      end
   endfunction

endpackage

// ===== src/mtf_if.sv =====
// ---------------------------------------------------------------------------
// Move-to-front list search channels
// Valid/ready channels for search requests, responses and the preload write.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mtf_req_if import mtf_pkg::*; ();
   logic    valid;
   logic    ready;
   key_type search_key;

   modport source (output valid, output search_key, input ready);
   modport sink   (input valid, input search_key, output ready);
endinterface

interface mtf_rsp_if import mtf_pkg::*; ();
   logic     valid;
   logic     ready;
   cost_type cost;
   logic     hit;
   logic     list_full;

   modport source (output valid, output cost, output hit, output list_full, input ready);
   modport sink   (input valid, input cost, input hit, input list_full, output ready);
endinterface

interface mtf_csr_if import mtf_pkg::*; ();
   logic      valid;
   logic      ready;
   count_type initial_count;

   modport source (output valid, output initial_count, input ready);
   modport sink   (input valid, input initial_count, output ready);
endinterface

// ===== src/move_to_front_list_search.sv =====
// ---------------------------------------------------------------------------
// Move-to-front list search
// Keyed search over a self-organizing list held in one synchronous memory.
// ---------------------------------------------------------------------------
// The slowest search is a hit on the last of 256 entries. The single read
// port of the list memory sets both the front-to-back scan (one entry a
// cycle) and the shift pass that opens the front slot (one entry a cycle).
// The front write and the response load follow. A full-list miss skips both
// the shift and the front write. A search is taken only while the block is
// idle. A response waiting in the output register does not block the next
// request. Writing initial_count reloads the list: per-entry valid bits are
// cleared and an entry not written since reads as its position plus one.
`timescale 1ns / 1ps

`include "move_to_front_list_search_assert.svh"

module move_to_front_list_search import mtf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   mtf_req_if.sink   req_ch,
   mtf_rsp_if.source rsp_ch,
   mtf_csr_if.sink   csr_ch
);

   // Control and result registers
   mtf_state_type state_ff, state_in;
   len_type       len_ff, len_in;
   len_type       idx_ff, idx_in;
   logic          pend_ff, pend_in;
   addr_type      pend_idx_ff, pend_idx_in;
   key_type       key_ff, key_in;
   cost_type      res_cost_ff, res_cost_in;
   logic          res_hit_ff, res_hit_in;
   logic          res_full_ff, res_full_in;
   logic          rsp_valid_ff, rsp_valid_in;
   cost_type      rsp_cost_ff, rsp_cost_in;
   logic          rsp_hit_ff, rsp_hit_in;
   logic          rsp_full_ff, rsp_full_in;

   // List memory and its valid bits
   key_type                list_mem_ff [LIST_DEPTH];
   logic [LIST_DEPTH-1:0]  valid_ff;
   key_type                rd_data_ff;
   logic                   rd_valid_ff;

   logic     mem_re;
   addr_type rd_addr;
   logic     mem_we;
   addr_type wr_addr;
   key_type  wr_data;

   logic     req_beat;
   logic     csr_beat;
   logic     rsp_free;
   key_type  entry;
   logic     match;
   len_type  idx_m1;

   assign req_beat = req_ch.valid && req_ch.ready;
   assign csr_beat = csr_ch.valid && csr_ch.ready;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign idx_m1   = idx_ff - LEN_W'(1);

   // Resolve the entry read last cycle: unwritten slots hold position plus one
   assign entry = rd_valid_ff ? rd_data_ff : (KEY_W'(pend_idx_ff) + KEY_W'(1));
   assign match = pend_ff && (entry == key_ff);

   assign req_ch.ready  = (state_ff == ST_IDLE);
   assign csr_ch.ready  = (state_ff == ST_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.cost      = rsp_cost_ff;
   assign rsp_ch.hit       = rsp_hit_ff;
   assign rsp_ch.list_full = rsp_full_ff;

   // Sequencer: scan, shift, front write, response load
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      key_in       = key_ff;
      res_cost_in  = res_cost_ff;
      res_hit_in   = res_hit_ff;
      res_full_in  = res_full_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_cost_in  = rsp_cost_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_full_in  = rsp_full_ff;
      mem_re       = 1'b0;
      rd_addr      = '0;
      mem_we       = 1'b0;
      wr_addr      = '0;
      wr_data      = key_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_beat) begin
               len_in = sat_count(csr_ch.initial_count);
            end
            if (req_beat) begin
               key_in   = req_ch.search_key;
               idx_in   = '0;
               state_in = ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (match) begin
               // Hit: move entries ahead of it down by one
               res_cost_in = COST_W'(LEN_W'(pend_idx_ff) + LEN_W'(1));
               res_hit_in  = 1'b1;
               res_full_in = 1'b0;
               idx_in      = LEN_W'(pend_idx_ff);
               state_in    = (pend_idx_ff == '0) ? ST_FRONT : ST_SHIFT;
            end else if (idx_ff == len_ff) begin
               // Miss: insert at the front unless the list is full
               res_cost_in = COST_W'(len_ff);
               res_hit_in  = 1'b0;
               if (len_ff >= LEN_W'(LIST_DEPTH)) begin
                  res_full_in = 1'b1;
                  state_in    = ST_OUT;
               end else begin
                  res_full_in = 1'b0;
                  len_in      = len_ff + LEN_W'(1);
                  state_in    = (len_ff == '0) ? ST_FRONT : ST_SHIFT;
               end
            end else begin
               // Advance the scan by one read
               mem_re      = 1'b1;
               rd_addr     = idx_ff[ADDR_W-1:0];
               pend_in     = 1'b1;
               pend_idx_in = idx_ff[ADDR_W-1:0];
               idx_in      = idx_ff + LEN_W'(1);
            end
         end

         ST_SHIFT: begin
            // Write back the entry read last cycle one slot further down
            if (pend_ff) begin
               mem_we  = 1'b1;
               wr_addr = pend_idx_ff + ADDR_W'(1);
               wr_data = entry;
            end
            if (idx_ff != '0) begin
               mem_re      = 1'b1;
               rd_addr     = idx_m1[ADDR_W-1:0];
               pend_in     = 1'b1;
               pend_idx_in = idx_m1[ADDR_W-1:0];
               idx_in      = idx_m1;
            end else begin
               state_in = ST_FRONT;
            end
         end

         ST_FRONT: begin
            mem_we   = 1'b1;
            wr_addr  = '0;
            wr_data  = key_ff;
            state_in = ST_OUT;
         end

         ST_OUT: begin
            // Hold the result until the output register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_cost_in  = res_cost_ff;
               rsp_hit_in   = res_hit_ff;
               rsp_full_in  = res_full_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      pend_idx_ff <= pend_idx_in;
      key_ff      <= key_in;
      res_cost_ff <= res_cost_in;
      res_hit_ff  <= res_hit_in;
      res_full_ff <= res_full_in;
      rsp_cost_ff <= rsp_cost_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_full_ff <= rsp_full_in;
   end

   // Entry valid bits: drop all on reload, set on each write
   always_ff @(posedge clock) begin
      if (reset || csr_beat) begin
         valid_ff <= '0;
      end else if (mem_we) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // List memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         list_mem_ff[wr_addr] <= wr_data;
      end
      if (mem_re) begin
         rd_data_ff  <= list_mem_ff[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // Checks
   `MTF_ASSERT_IMPLY(a_len_bound, 1'b1, len_ff <= LEN_W'(LIST_DEPTH), "list length above depth")
   `MTF_ASSERT_IMPLY(a_we_state, mem_we, (state_ff == ST_SHIFT) || (state_ff == ST_FRONT),
      "list write outside shift or front write")
   `MTF_ASSERT_IMPLY(a_rw_apart, mem_we && mem_re, wr_addr != rd_addr,
      "read and write on the same entry")
   `MTF_ASSERT_NEXT(a_out_load, (state_ff == ST_OUT) && rsp_free,
      (state_ff == ST_IDLE) && rsp_valid_ff, "result not loaded into the output register")
   `MTF_ASSERT_IMPLY(a_hit_not_full, rsp_valid_ff, !(rsp_hit_ff && rsp_full_ff),
      "hit response flagged full")

endmodule

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// Move-to-front list search testbench
// Drives search keys and preload writes, tracks the list in a local model and
// checks every response beat against the model, under source and sink gaps.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import mtf_pkg::*;

   typedef struct packed {
      cost_type cost;
      logic     hit;
      logic     list_full;
   } search_result_type;

   logic clock;
   logic reset;

   mtf_req_if req_ch ();
   mtf_rsp_if rsp_ch ();
   mtf_csr_if csr_ch ();

   move_to_front_list_search dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Local copy of the list, front at index 0
   key_type     list_model [LIST_DEPTH];
   int unsigned list_len;

   search_result_type pending_results [$];
   int unsigned       mismatch_count;
   int unsigned       send_idle_pct;
   int unsigned       rsp_stall_pct;
   bit                rsp_hold;

   // Reload the list with 1..count, clamped to the depth
   function automatic void reload_list_model(count_type count);
      int unsigned n;
      n = (int'(count) > LIST_DEPTH) ? LIST_DEPTH : int'(count);
      for (int i = 0; i < LIST_DEPTH; i++) begin
         list_model[i] = (i < n) ? key_type'(i + 1) : '0;
      end
      list_len = n;
   endfunction

   // Walk the list, move a hit to the front, insert a miss unless full
   function automatic search_result_type search_and_reorder(key_type key);
      search_result_type res;
      int unsigned       pos;
      res = '0;
      pos = 0;
      while (pos < list_len && list_model[pos] != key) begin
         pos++;
      end
      if (pos < list_len) begin
         res.hit  = 1'b1;
         res.cost = cost_type'(pos + 1);
         for (int i = pos; i > 0; i--) begin
            list_model[i] = list_model[i-1];
         end
         list_model[0] = key;
      end else begin
         res.cost = cost_type'(list_len);
         if (list_len >= LIST_DEPTH) begin
            res.list_full = 1'b1;
         end else begin
            for (int i = list_len; i > 0; i--) begin
               list_model[i] = list_model[i-1];
            end
            list_model[0] = key;
            list_len++;
         end
      end
      return res;
   endfunction

   // Half from the list, often near the front, then small values, wide values and extremes
   function automatic key_type pick_search_key();
      int unsigned sel;
      int unsigned span;
      sel = $urandom_range(99);
      if (sel < 50 && list_len != 0) begin
         span = (sel < 30 && list_len > 8) ? 8 : list_len;
         return list_model[$urandom_range(span - 1)];
      end else if (sel < 75) begin
         return key_type'($urandom_range(300));
      end else if (sel < 95) begin
         return key_type'($urandom);
      end else begin
         return sel[0] ? '1 : '0;
      end
   endfunction

   // Clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog
   initial begin
      #20000000;
      $display("Mismatches found");
      $finish;
   end

   // Response sink: random stalls, or a held-off stretch when requested
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Check each response beat against the oldest prediction
   always @(posedge clock) begin
      search_result_type exp_res;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            $error("response beat with no search pending: cost %0d hit %0d list_full %0d",
                   rsp_ch.cost, rsp_ch.hit, rsp_ch.list_full);
            mismatch_count++;
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_ch.cost !== exp_res.cost) begin
               $error("cost mismatch: expected %0d, actual %0d", exp_res.cost, rsp_ch.cost);
               mismatch_count++;
            end
            if (rsp_ch.hit !== exp_res.hit) begin
               $error("hit mismatch: expected %0d, actual %0d", exp_res.hit, rsp_ch.hit);
               mismatch_count++;
            end
            if (rsp_ch.list_full !== exp_res.list_full) begin
               $error("list_full mismatch: expected %0d, actual %0d",
                      exp_res.list_full, rsp_ch.list_full);
               mismatch_count++;
            end
         end
      end
   end

   // Offer one key; entered and left at a falling edge with valid still high
   task automatic send_search(key_type key);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.search_key <= key;
      do @(posedge clock); while (!req_ch.ready);
      pending_results.push_back(search_and_reorder(key));
      @(negedge clock);
   endtask

   // Drop valid, then wait for every response and a short settle time
   task automatic wait_search_idle();
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (8) @(negedge clock);
   endtask

   // Write the preload count while idle and reload the model
   task automatic write_preload(count_type count);
      wait_search_idle();
      csr_ch.initial_count <= count;
      csr_ch.valid         <= 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
      reload_list_model(count);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic send_keys(key_type keys [$]);
      foreach (keys[i]) begin
         send_search(keys[i]);
      end
   endtask

   // Empty list out of reset: miss with zero cost, hit the inserted key, then miss on zero
   task automatic test_reset_empty_list();
      send_keys('{32'd5, 32'd5, 32'd0});
   endtask

   task automatic test_key_extremes();
      write_preload(count_type'(0));
      send_keys('{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h0000_0000, 32'hFFFF_FFFF});
   endtask

   task automatic test_move_to_front();
      write_preload(count_type'(4));
      send_keys('{32'd4, 32'd4, 32'd1, 32'd2, 32'd99, 32'd3, 32'd99});
   endtask

   // Full list: deepest hit, further hits, and misses that must not insert
   task automatic test_full_list();
      write_preload(count_type'(LIST_DEPTH));
      send_keys('{32'd256, 32'd256, 32'd1, 32'hDEAD_BEEF, 32'd0, 32'd128});
   endtask

   // Counts above the depth clamp to a full list
   task automatic test_count_saturation();
      write_preload(count_type'(511));
      send_keys('{32'd256, 32'd257});
      write_preload(count_type'(257));
      send_keys('{32'd256});
   endtask

   // One slot left: the first miss fills it, the next one reports full
   task automatic test_fill_to_full();
      write_preload(count_type'(LIST_DEPTH - 1));
      send_keys('{32'd1000, 32'd1001, 32'd1000});
   endtask

   // Hold the response sink off for a long stretch while keys keep coming
   task automatic test_output_backpressure();
      write_preload(count_type'(3));
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      rsp_hold      = 1'b1;
      fork
         begin
            repeat (3000) @(posedge clock);
            rsp_hold = 1'b0;
         end
      join_none
      for (int i = 0; i < 12; i++) begin
         send_search(pick_search_key());
      end
      wait_search_idle();
   endtask

   task automatic test_random_searches(int unsigned n_items, count_type preload,
                                       int unsigned idle_pct, int unsigned stall_pct);
      write_preload(preload);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < n_items; i++) begin
         send_search(pick_search_key());
      end
      wait_search_idle();
   endtask

   initial begin
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.search_key    = '0;
      csr_ch.valid         = 1'b0;
      csr_ch.initial_count = '0;
      mismatch_count       = 0;
      send_idle_pct        = 0;
      rsp_stall_pct        = 0;
      rsp_hold             = 1'b0;
      reload_list_model(count_type'(0));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_empty_list();
      test_key_extremes();
      test_move_to_front();
      test_full_list();
      test_count_saturation();
      test_fill_to_full();
      test_output_backpressure();

      test_random_searches(220, count_type'(8), 0, 0);
      test_random_searches(140, count_type'(250), 72, 0);
      test_random_searches(220, count_type'(0), 0, 72);
      test_random_searches(220, count_type'($urandom_range(1, 64)), 24, 24);

      // Catch any stray response beat before the verdict
      wait_search_idle();
      repeat (600) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== move_to_front_list_search.f =====
+incdir+src
src/mtf_pkg.sv
src/mtf_if.sv
src/move_to_front_list_search.sv
tb/tb.sv
